FILE: rtl/hsv_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_macros.svh
// Assertion macros for the HSV to RGB converter. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define H2R_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("h2r: same-cycle check failed");

// next-cycle implication
`define H2R_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("h2r: next-cycle check failed");

`endif

FILE: rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared constants, stage beat types and sector codes of the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int SW         = FRAC_BITS + 1;

	localparam int HUE_W      = 16;
	localparam int SV_IN_W    = 11;
	localparam int CH_W       = 8;

	localparam int DEG_FULL   = 360;
	localparam int DEG_SECTOR = 60;
	localparam int SECTORS    = 6;
	localparam int CHAN_MAX   = 255;

	localparam int SEC_W      = $clog2(SECTORS);
	localparam int REM_W      = $clog2(DEG_SECTOR);
	localparam int HMOD_W     = $clog2(DEG_FULL);

	localparam int EXT_W      = (SV_IN_W > SW + 1) ? SV_IN_W : SW + 1;

	// hue is biased positive by a multiple of 360, then reduced by reciprocal
	localparam int HUE_OFS    = DEG_FULL * ((2 ** (HUE_W - 1) + DEG_FULL - 1) / DEG_FULL);
	localparam int HU_W       = HUE_W + 1;
	localparam int HRCP       = (2 ** HU_W) / DEG_FULL;
	localparam int HRCP_W     = $clog2(HRCP + 1);

	// shade path: BIG = 60 * ONE
	localparam int BIG        = DEG_SECTOR * ONE;
	localparam int BW         = $clog2(BIG + 1);
	localparam int PW         = SW + BW;
	localparam int DRCP       = (2 ** BW) / DEG_SECTOR;
	localparam int DRCP_W     = $clog2(DRCP + 1);

	localparam int CHP_W      = SW + CH_W;

	typedef enum logic [SEC_W-1:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t          sector;
		logic [REM_W-1:0] rem;
		logic [SW-1:0]    sat;
		logic [SW-1:0]    val;
	} hue_beat_t;

	typedef struct packed {
		sector_t       sector;
		logic [SW-1:0] val;
		logic [SW-1:0] p;
		logic [SW-1:0] q;
		logic [SW-1:0] t;
	} shade_beat_t;

endpackage

FILE: rtl/h2r_front.sv
// ----------------------------------------------------------------------------
// h2r_front
// Stages 1 to 3: clamps saturation and value, reduces the hue modulo 360 and
// splits it into sector and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_front import h2r_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [HUE_W-1:0]   hue_degrees,
	input  logic signed [SV_IN_W-1:0] saturation,
	input  logic signed [SV_IN_W-1:0] brightness,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hue_beat_t                 out_beat
);

	function automatic logic [SW-1:0] clamp_unit(input logic signed [SV_IN_W-1:0] x);
		logic signed [EXT_W-1:0] xe;
		xe = EXT_W'(x);
		if (xe < 0)
			return '0;
		else if (xe > EXT_W'(ONE))
			return SW'(ONE);
		else
			return xe[SW-1:0];
	endfunction

	logic                       valid_s1, valid_s2, valid_s3;
	logic                       en_s1, en_s2, en_s3;
	logic [HU_W-1:0]            hu_s1;
	logic [HRCP_W-1:0]          hq_s1;
	logic [SW-1:0]              sat_s1, val_s1, sat_s2, val_s2;
	logic [HMOD_W-1:0]          hmod_s2;
	hue_beat_t                  beat_s3;

	logic [HU_W-1:0]            hu_c;
	logic [HU_W+HRCP_W-1:0]     hprod_c;
	logic [HU_W-1:0]            hr_c, hm_c;
	logic [SEC_W-1:0]           sec_c;
	logic [HMOD_W-1:0]          rem_c;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = valid_s3;
	assign out_beat  = beat_s3;

	assign hu_c    = HU_W'(hue_degrees) + HU_W'(HUE_OFS);
	assign hprod_c = (HU_W+HRCP_W)'(hu_c) * (HU_W+HRCP_W)'(HRCP);

	assign hr_c = hu_s1 - HU_W'(hq_s1) * HU_W'(DEG_FULL);
	assign hm_c = (hr_c >= HU_W'(DEG_FULL)) ? hr_c - HU_W'(DEG_FULL) : hr_c;

	always_comb begin
		sec_c = '0;
		for (int k = 1; k < SECTORS; k++) begin
			if (hmod_s2 >= HMOD_W'(k * DEG_SECTOR))
				sec_c = SEC_W'(k);
		end
		rem_c = hmod_s2 - HMOD_W'(sec_c) * HMOD_W'(DEG_SECTOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			hu_s1  <= hu_c;
			hq_s1  <= hprod_c[HU_W +: HRCP_W];
			sat_s1 <= clamp_unit(saturation);
			val_s1 <= clamp_unit(brightness);
		end
		if (en_s2 && valid_s1) begin
			hmod_s2 <= hm_c[HMOD_W-1:0];
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
		if (en_s3 && valid_s2) begin
			beat_s3.sector <= sector_t'(sec_c);
			beat_s3.rem    <= rem_c[REM_W-1:0];
			beat_s3.sat    <= sat_s2;
			beat_s3.val    <= val_s2;
		end
	end

endmodule

FILE: rtl/h2r_shade.sv
// ----------------------------------------------------------------------------
// h2r_shade
// Stages 4 to 7: forms p, q and t. Division by 60*ONE is a shift followed by
// a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_shade import h2r_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  hue_beat_t   in_beat,
	output logic        out_valid,
	input  logic        out_ready,
	output shade_beat_t out_beat
);

	function automatic logic [SW-1:0] fix_quot(input logic [BW-1:0] y,
		input logic [SW-1:0] qh);
		logic [BW-1:0] r;
		r = y - BW'(qh) * BW'(DEG_SECTOR);
		return (r >= BW'(DEG_SECTOR)) ? qh + SW'(1) : qh;
	endfunction

	logic                   valid_s4, valid_s5, valid_s6, valid_s7;
	logic                   en_s4, en_s5, en_s6, en_s7;

	sector_t                sec_s4, sec_s5, sec_s6;
	logic [SW-1:0]          val_s4, val_s5, val_s6;
	logic [BW-1:0]          sr_s4, sf_s4;
	logic [2*SW-1:0]        pm_s4;
	logic [PW-1:0]          pa_s5, pb_s5;
	logic [SW-1:0]          p_s5, p_s6;
	logic [BW-1:0]          ya_s6, yb_s6;
	logic [SW-1:0]          qa_s6, qb_s6;
	shade_beat_t            beat_s7;

	logic [BW-1:0]          ya_c, yb_c;
	logic [BW+DRCP_W-1:0]   ma_c, mb_c;

	assign en_s7     = !valid_s7 || out_ready;
	assign en_s6     = !valid_s6 || en_s7;
	assign en_s5     = !valid_s5 || en_s6;
	assign en_s4     = !valid_s4 || en_s5;
	assign in_ready  = en_s4;
	assign out_valid = valid_s7;
	assign out_beat  = beat_s7;

	assign ya_c = pa_s5[FRAC_BITS +: BW];
	assign yb_c = pb_s5[FRAC_BITS +: BW];
	assign ma_c = (BW+DRCP_W)'(ya_c) * (BW+DRCP_W)'(DRCP);
	assign mb_c = (BW+DRCP_W)'(yb_c) * (BW+DRCP_W)'(DRCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en_s4)
				valid_s4 <= in_valid;
			if (en_s5)
				valid_s5 <= valid_s4;
			if (en_s6)
				valid_s6 <= valid_s5;
			if (en_s7)
				valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			sec_s4 <= in_beat.sector;
			val_s4 <= in_beat.val;
			sr_s4  <= BW'(in_beat.sat) * BW'(in_beat.rem);
			sf_s4  <= BW'(in_beat.sat) * (BW'(DEG_SECTOR) - BW'(in_beat.rem));
			pm_s4  <= (2*SW)'(in_beat.val) * (2*SW)'(SW'(ONE) - in_beat.sat);
		end
		if (en_s5 && valid_s4) begin
			sec_s5 <= sec_s4;
			val_s5 <= val_s4;
			pa_s5  <= PW'(val_s4) * PW'(BW'(BIG) - sr_s4);
			pb_s5  <= PW'(val_s4) * PW'(BW'(BIG) - sf_s4);
			p_s5   <= pm_s4[FRAC_BITS +: SW];
		end
		if (en_s6 && valid_s5) begin
			sec_s6 <= sec_s5;
			val_s6 <= val_s5;
			p_s6   <= p_s5;
			ya_s6  <= ya_c;
			yb_s6  <= yb_c;
			qa_s6  <= ma_c[BW +: SW];
			qb_s6  <= mb_c[BW +: SW];
		end
		if (en_s7 && valid_s6) begin
			beat_s7.sector <= sec_s6;
			beat_s7.val    <= val_s6;
			beat_s7.p      <= p_s6;
			beat_s7.q      <= fix_quot(ya_s6, qa_s6);
			beat_s7.t      <= fix_quot(yb_s6, qb_s6);
		end
	end

endmodule

FILE: rtl/h2r_chan_out.sv
// ----------------------------------------------------------------------------
// h2r_chan_out
// Stage 8: routes v, p, q, t to the channels by sector, scales each by
// 255/ONE and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_chan_out import h2r_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  shade_beat_t     in_beat,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue
);

	function automatic logic [CH_W-1:0] to_chan(input logic [SW-1:0] x);
		logic [CHP_W-1:0] m;
		m = CHP_W'(x) * CHP_W'(CHAN_MAX);
		return m[FRAC_BITS +: CH_W];
	endfunction

	logic            valid_s8;
	logic            en_s8;
	logic [SW-1:0]   r_c, g_c, b_c;
	logic [CH_W-1:0] red_s8, green_s8, blue_s8;

	assign en_s8     = !valid_s8 || out_ready;
	assign in_ready  = en_s8;
	assign out_valid = valid_s8;
	assign red       = red_s8;
	assign green     = green_s8;
	assign blue      = blue_s8;

	always_comb begin
		case (in_beat.sector)
			SEC_YEL_GRN: begin
				r_c = in_beat.q;   g_c = in_beat.val; b_c = in_beat.p;
			end
			SEC_GRN_CYN: begin
				r_c = in_beat.p;   g_c = in_beat.val; b_c = in_beat.t;
			end
			SEC_CYN_BLU: begin
				r_c = in_beat.p;   g_c = in_beat.q;   b_c = in_beat.val;
			end
			SEC_BLU_MAG: begin
				r_c = in_beat.t;   g_c = in_beat.p;   b_c = in_beat.val;
			end
			SEC_MAG_RED: begin
				r_c = in_beat.val; g_c = in_beat.p;   b_c = in_beat.q;
			end
			default: begin
				r_c = in_beat.val; g_c = in_beat.t;   b_c = in_beat.p;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s8 <= 1'b0;
		else if (en_s8)
			valid_s8 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s8 && in_valid) begin
			red_s8   <= to_chan(r_c);
			green_s8 <= to_chan(g_c);
			blue_s8  <= to_chan(b_c);
		end
	end

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to 8-bit RGB conversion, eight-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high and returns one RGB beat
// per input beat, in order. The eight register stages are hue reduction
// (three stages), the p/q/t products and reciprocal divides (four stages)
// and the channel scaling and output register (one stage). Each stage holds
// its beat while the stage after it is full, so a stall at the output backs
// up without loss and bubbles are squeezed out; in_ready drops only when
// every stage is full and the output is not taken. Hue is any signed degree
// count; saturation and brightness are clamped to 0..1.0 with
// 1.0 = 2^FRAC_BITS.
`timescale 1ns / 1ps

`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter import h2r_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [HUE_W-1:0]   hue_degrees,
	input  logic signed [SV_IN_W-1:0] saturation,
	input  logic signed [SV_IN_W-1:0] brightness,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CH_W-1:0]           red,
	output logic [CH_W-1:0]           green,
	output logic [CH_W-1:0]           blue
);

	logic        f_valid, f_ready;
	hue_beat_t   f_beat;
	logic        s_valid, s_ready;
	shade_beat_t s_beat;

	h2r_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.out_beat    (f_beat)
	);

	h2r_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_beat   (f_beat),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_beat  (s_beat)
	);

	h2r_chan_out u_chan_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_beat   (s_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// backpressure only comes from a held output beat
	`H2R_ASSERT_IMPL(a_in_stall_full, !in_ready, out_valid && !out_ready)
	`H2R_ASSERT_IMPL(a_shade_stall, s_valid && !s_ready, out_valid && !out_ready)
	// an output beat appears only from a valid shade beat
	`H2R_ASSERT_NEXT(a_out_source, !out_valid && !s_valid, !out_valid)

endmodule
